FILE: rtl/image_compression_error_meter_assert.svh
// Assertion macros for the compression error meter.
// Used by the top level; expects clk and rst in scope.
`ifndef IMAGE_COMPRESSION_ERROR_METER_ASSERT_SVH
`define IMAGE_COMPRESSION_ERROR_METER_ASSERT_SVH
// pre holds -> post holds in the same cycle
`define ICEM_ASSERT_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("icem: implication check failed");
// pre holds -> post holds in the next cycle
`define ICEM_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("icem: next-cycle check failed");
`endif

FILE: rtl/icem_pkg.sv
// Shared types, register codes and the CORDIC angle table of the error meter.
// No dependencies.
`default_nettype none
package icem_pkg;

  typedef struct packed {
    logic [15:0] orig_red;
    logic [15:0] orig_green;
    logic [15:0] orig_blue;
    logic [15:0] comp_red;
    logic [15:0] comp_green;
    logic [15:0] comp_blue;
    logic        final_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [31:0] mean_error;
    logic [24:0] pixels_seen;
  } err_out_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] weight_red;
    logic [15:0] weight_green;
    logic [15:0] weight_blue;
    pix_in_t     pix;
  } job_t;

  typedef struct packed {
    logic busy;
    logic dividing;
  } back_stat_t;

  typedef enum logic [1:0] {
    REG_ERROR_MODE   = 2'd0,
    REG_WEIGHT_RED   = 2'd1,
    REG_WEIGHT_GREEN = 2'd2,
    REG_WEIGHT_BLUE  = 2'd3
  } reg_idx_t;

  localparam logic        MODE_NORMAL  = 1'b0;
  localparam logic        MODE_COLOR   = 1'b1;
  localparam logic [15:0] WEIGHT_RESET = 16'd16384;

  // atan(2^-i) in Q.24 radians
  function automatic logic [24:0] angle_step(input logic [4:0] i);
    logic [24:0] a;
    case (i)
      5'd0:  a = 25'd13176795;
      5'd1:  a = 25'd7778716;
      5'd2:  a = 25'd4110060;
      5'd3:  a = 25'd2086331;
      5'd4:  a = 25'd1047214;
      5'd5:  a = 25'd524117;
      5'd6:  a = 25'd262123;
      5'd7:  a = 25'd131069;
      5'd8:  a = 25'd65536;
      5'd9:  a = 25'd32768;
      5'd10: a = 25'd16384;
      5'd11: a = 25'd8192;
      5'd12: a = 25'd4096;
      5'd13: a = 25'd2048;
      5'd14: a = 25'd1024;
      5'd15: a = 25'd512;
      5'd16: a = 25'd256;
      5'd17: a = 25'd128;
      5'd18: a = 25'd64;
      5'd19: a = 25'd32;
      5'd20: a = 25'd16;
      5'd21: a = 25'd8;
      5'd22: a = 25'd4;
      5'd23: a = 25'd2;
      default: a = 25'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/icem_front.sv
// Front end: configuration registers and input acceptance.
// Tags each accepted pixel pair with the mode and weights. Uses icem_pkg.
`default_nettype none
module icem_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire icem_pkg::reg_idx_t cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              push,
  output logic                   full,
  input  wire icem_pkg::pix_in_t pixel,
  input  wire logic              q_full,
  output logic                   q_push,
  output icem_pkg::job_t         q_job
);
  import icem_pkg::*;

  logic        mode;
  logic [15:0] weight_red;
  logic [15:0] weight_green;
  logic [15:0] weight_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      weight_red   <= WEIGHT_RESET;
      weight_green <= WEIGHT_RESET;
      weight_blue  <= WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ERROR_MODE:   mode         <= cfg_data[0];
        REG_WEIGHT_RED:   weight_red   <= cfg_data;
        REG_WEIGHT_GREEN: weight_green <= cfg_data;
        REG_WEIGHT_BLUE:  weight_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_job.mode         = mode;
    q_job.weight_red   = weight_red;
    q_job.weight_green = weight_green;
    q_job.weight_blue  = weight_blue;
    q_job.pix          = pixel;
  end

endmodule
`default_nettype wire

FILE: rtl/icem_queue.sv
// Two-entry job queue between front and back end.
// Uses icem_pkg.
`default_nettype none
module icem_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire icem_pkg::job_t wr_job,
  output logic                q_full,
  input  wire logic           rd,
  output icem_pkg::job_t      rd_job,
  output logic                q_empty
);
  import icem_pkg::*;

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_job;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= !wptr;
      end
      if (rd) begin
        rptr <= !rptr;
      end
      case ({wr, rd})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign rd_job  = slots[rptr];
  assign q_full  = (fill == 2'd2);
  assign q_empty = (fill == 2'd0);

endmodule
`default_nettype wire

FILE: rtl/icem_back.sv
// Back end: per-pair error, accumulation, mean by long division, result register.
// One shared 32x32 multiplier, a bit-pair square root, CORDIC and a bit-serial divider.
`default_nettype none
module icem_back #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire icem_pkg::job_t  q_job,
  output logic                 q_pop,
  output icem_pkg::err_out_t   result,
  output logic                 empty,
  input  wire logic            pop,
  output icem_pkg::back_stat_t stat
);
  import icem_pkg::*;

  localparam int CW = MAX_PIXELS_LOG2 + 1;
  localparam logic [CW-1:0] LIMIT = CW'(1) << MAX_PIXELS_LOG2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_ROOT, ST_DOT, ST_DSQ, ST_CORDIC, ST_COLOR, ST_ACCUM, ST_DIV, ST_EMIT
  } state_t;
  typedef enum logic [1:0] {R_Z1, R_Z2, R_W} root_t;

  state_t      state;
  root_t       phase;
  logic [5:0]  step;
  job_t        job;
  logic [16:0] ax1, ay1, ax2, ay2;
  logic        sx1, sy1, sx2, sy2;
  logic [16:0] z1, z2;
  logic [30:0] d;
  logic [63:0] acc;
  logic [31:0] pm;
  logic [61:0] rt_rem, rt_res;
  logic signed [33:0] cx, cy;
  logic signed [26:0] ang;
  logic [31:0] err;
  logic [63:0] error_sum;
  logic [CW-1:0] pair_count;
  logic [63:0] dvd;
  logic [CW-1:0] drem;
  logic        out_valid;

  // combinational helpers
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod, prod_s;
  logic        neg;
  logic [1:0]  chan;
  logic [15:0] ca, cb, cwt, cmag;
  logic [63:0] sumsq, sq_v, acc_dot;
  logic [61:0] rt_bit, rt_trial, rt_res_next, rt_rem_next;
  logic signed [33:0] cdx, cdy, cx_next, cy_next;
  logic signed [26:0] ang_next;
  logic [CW:0] dtrial, ddiff;
  logic        dge;
  logic [63:0] sum_new;
  logic [CW-1:0] count_new;
  logic [63:0] cnt_wide;

  function automatic logic [16:0] mag_of(input logic [15:0] r);
    return r[15] ? {1'b0, r[14:0], 1'b0} : 17'd65536 - {r, 1'b0};
  endfunction

  always_comb begin
    chan = step[2:1];
    case (chan)
      2'd0:    begin ca = job.pix.orig_red;   cb = job.pix.comp_red;   cwt = job.weight_red;   end
      2'd1:    begin ca = job.pix.orig_green; cb = job.pix.comp_green; cwt = job.weight_green; end
      default: begin ca = job.pix.orig_blue;  cb = job.pix.comp_blue;  cwt = job.weight_blue;  end
    endcase
    cmag = (ca >= cb) ? ca - cb : cb - ca;

    mul_a = '0;
    mul_b = '0;
    neg   = 1'b0;
    case (state)
      ST_SQ: begin
        if (phase == R_Z1) begin
          mul_a = 32'(step[0] ? ay1 : ax1);
        end else begin
          mul_a = 32'(step[0] ? ay2 : ax2);
        end
        mul_b = mul_a;
      end
      ST_DOT: begin
        case (step[1:0])
          2'd0:    begin mul_a = 32'(ax1); mul_b = 32'(ax2); neg = sx1 ^ sx2; end
          2'd1:    begin mul_a = 32'(ay1); mul_b = 32'(ay2); neg = sy1 ^ sy2; end
          default: begin mul_a = 32'(z1);  mul_b = 32'(z2);  end
        endcase
      end
      ST_DSQ: begin
        mul_a = 32'(d);
        mul_b = 32'(d);
      end
      ST_COLOR: begin
        if (step[0]) begin
          mul_a = pm;
          mul_b = pm;
        end else begin
          mul_a = 32'(cmag);
          mul_b = 32'(cwt);
        end
      end
      default: ;
    endcase
    prod   = mul_a * mul_b;
    prod_s = neg ? (~prod + 64'd1) : prod;

    sumsq   = acc + prod;
    sq_v    = (sumsq > 64'h1_0000_0000) ? 64'd0 : 64'h1_0000_0000 - sumsq;
    acc_dot = acc + prod_s;

    rt_bit   = 62'(1) << (6'd60 - {step[4:0], 1'b0});
    rt_trial = rt_res + rt_bit;
    if (rt_rem >= rt_trial) begin
      rt_rem_next = rt_rem - rt_trial;
      rt_res_next = (rt_res >> 1) + rt_bit;
    end else begin
      rt_rem_next = rt_rem;
      rt_res_next = rt_res >> 1;
    end

    cdx = cy >>> step;
    cdy = cx >>> step;
    if (!cy[33]) begin
      cx_next  = cx + cdx;
      cy_next  = cy - cdy;
      ang_next = ang + $signed({2'b00, angle_step(step[4:0])});
    end else begin
      cx_next  = cx - cdx;
      cy_next  = cy + cdy;
      ang_next = ang - $signed({2'b00, angle_step(step[4:0])});
    end

    dtrial = {drem, dvd[63]};
    ddiff  = dtrial - {1'b0, pair_count};
    dge    = (dtrial >= {1'b0, pair_count});

    if (pair_count < LIMIT) begin
      sum_new   = error_sum + 64'(err);
      count_new = pair_count + CW'(1);
    end else begin
      sum_new   = error_sum;
      count_new = pair_count;
    end
    cnt_wide = 64'(pair_count);

    q_pop         = (state == ST_IDLE) && !q_empty;
    stat.busy     = (state != ST_IDLE);
    stat.dividing = (state == ST_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= R_Z1;
      step       <= '0;
      error_sum  <= '0;
      pair_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // the emit state handles its own pop
      if (pop && out_valid && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job   <= q_job;
            ax1   <= mag_of(q_job.pix.orig_red);
            ay1   <= mag_of(q_job.pix.orig_green);
            ax2   <= mag_of(q_job.pix.comp_red);
            ay2   <= mag_of(q_job.pix.comp_green);
            sx1   <= !q_job.pix.orig_red[15];
            sy1   <= !q_job.pix.orig_green[15];
            sx2   <= !q_job.pix.comp_red[15];
            sy2   <= !q_job.pix.comp_green[15];
            acc   <= '0;
            step  <= '0;
            phase <= R_Z1;
            state <= (q_job.mode == MODE_COLOR) ? ST_COLOR : ST_SQ;
          end
        end
        ST_SQ: begin
          acc <= sumsq;
          if (step[0]) begin
            rt_rem <= 62'(sq_v);
            rt_res <= '0;
            step   <= '0;
            state  <= ST_ROOT;
          end else begin
            step <= step + 6'd1;
          end
        end
        ST_ROOT: begin
          rt_rem <= rt_rem_next;
          rt_res <= rt_res_next;
          if (step == 6'd30) begin
            step <= '0;
            acc  <= '0;
            case (phase)
              R_Z1: begin
                z1    <= 17'(rt_res_next);
                phase <= R_Z2;
                state <= ST_SQ;
              end
              R_Z2: begin
                z2    <= 17'(rt_res_next);
                state <= ST_DOT;
              end
              default: begin
                cx    <= 34'(d);
                cy    <= 34'(rt_res_next);
                ang   <= '0;
                state <= ST_CORDIC;
              end
            endcase
          end else begin
            step <= step + 6'd1;
          end
        end
        ST_DOT: begin
          acc  <= acc_dot;
          step <= step + 6'd1;
          if (step == 6'd2) begin
            // clamp the dot product to [0, 1.0] in Q.32, keep Q.30
            if (acc_dot[63]) begin
              d <= '0;
            end else if (acc_dot > 64'h1_0000_0000) begin
              d <= 31'h4000_0000;
            end else begin
              d <= acc_dot[32:2];
            end
            state <= ST_DSQ;
          end
        end
        ST_DSQ: begin
          rt_rem <= 62'(64'h1000_0000_0000_0000 - prod);
          rt_res <= '0;
          step   <= '0;
          phase  <= R_W;
          state  <= ST_ROOT;
        end
        ST_CORDIC: begin
          cx   <= cx_next;
          cy   <= cy_next;
          ang  <= ang_next;
          step <= step + 6'd1;
          if (step == 6'd23) begin
            err   <= ang_next[26] ? 32'd0 : 32'(ang_next);
            state <= ST_ACCUM;
          end
        end
        ST_COLOR: begin
          step <= step + 6'd1;
          if (!step[0]) begin
            pm <= prod[31:0];
          end else begin
            acc <= acc + (prod >> 2);
          end
          if (step == 6'd5) begin
            err   <= 32'((acc + (prod >> 2)) >> 34);
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          error_sum  <= sum_new;
          pair_count <= count_new;
          if (job.pix.final_pixel) begin
            dvd   <= sum_new;
            drem  <= '0;
            step  <= '0;
            state <= ST_DIV;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          drem <= dge ? ddiff[CW-1:0] : dtrial[CW-1:0];
          dvd  <= {dvd[62:0], dge};
          step <= step + 6'd1;
          if (step == 6'd63) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || pop) begin
            result.mean_error  <= (|dvd[63:32]) ? 32'hFFFF_FFFF : dvd[31:0];
            result.pixels_seen <= cnt_wide[24:0];
            out_valid          <= 1'b1;
            error_sum          <= '0;
            pair_count         <= '0;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign empty = !out_valid;

endmodule
`default_nettype wire

FILE: rtl/image_compression_error_meter.sv
// Compression error meter, top level: front end, job queue and back end.
// Uses icem_pkg, icem_front, icem_queue, icem_back and the assertion macros.
//
// Each transfer on the input side is one pixel pair, original and compressed copy,
// channels unsigned Q0.16. In normal mode (error_mode 0) red and green of each pixel
// are read as a unit normal, z is rebuilt, and the angle between the two normals in
// Q.24 radians is added to a running sum. In color mode (error_mode 1) the squared
// distance between the Q2.14-weighted RGB values is added instead. On the pair marked
// final_pixel one result transfer comes out: the floored mean (Q8.24, saturating) and
// the number of pairs, and the sum and count clear. Once 2^MAX_PIXELS_LOG2 pairs are
// counted further pairs add nothing. The back end works on one pair at a time
// with one shared 32x32 multiplier and a bit-pair square root unit. A normal-mode
// pair takes three roots and 24 CORDIC iterations; a final pair adds bit-serial
// division and a load of the result register. A two-entry queue lets the input side
// take up to two pairs while the back end is busy, and the result register lets work
// continue while a result waits to be popped. Configuration is to be written only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "image_compression_error_meter_assert.svh"
module image_compression_error_meter #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_we,
  input  wire icem_pkg::reg_idx_t cfg_index,
  input  wire logic [15:0]        cfg_data,
  // pixel pairs in
  input  wire logic               push,
  output logic                    full,
  input  wire icem_pkg::pix_in_t  pixel,
  // results out
  output logic                    empty,
  input  wire logic               pop,
  output icem_pkg::err_out_t      result
);
  import icem_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  job_t       push_job;
  job_t       head_job;
  back_stat_t stat;

  icem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  icem_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_job  (push_job),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_job  (head_job),
    .q_empty (q_empty)
  );

  icem_back #(
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop),
    .stat    (stat)
  );

  // back end never reads an empty queue
  `ICEM_ASSERT_IMPLIES(a_pop_nonempty, q_pop, !q_empty)
  // a transfer into an empty queue is visible next cycle
  `ICEM_ASSERT_NEXT(a_push_lands, q_push && q_empty, !q_empty)
  // no new pair is taken while the mean is being divided out
  `ICEM_ASSERT_IMPLIES(a_div_no_take, stat.dividing, !q_pop)
  // a result only appears after back-end work
  `ICEM_ASSERT_IMPLIES(a_result_from_work, !empty && $past(empty), $past(stat.busy))

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Testbench for image_compression_error_meter: random and directed pixel-pair sets,
// checked against a bit-exact mean-error predictor. Depends on icem_pkg and the RTL top.
`timescale 1ns / 1ps
module tb;
  import icem_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int STALL_MAX  = 20000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT = 600;    // > a full queue plus one pair in work, all normal, and the divide
  localparam int PIX_LIMIT_LOG2 = 24;

  // atan(2^-i), Q.24 radians
  localparam longint ATAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  reg_idx_t   cfg_index = REG_ERROR_MODE;
  logic [15:0] cfg_data = '0;
  logic       push = 1'b0;
  logic       full;
  pix_in_t    pixel = '0;
  logic       empty;
  logic       pop = 1'b0;
  err_out_t   result;

  image_compression_error_meter dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .pixel(pixel),
    .empty(empty), .pop(pop), .result(result)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // pixel pairs waiting to be pushed, means waiting to be popped
  pix_in_t  pending_pairs[$];
  err_out_t expected_means[$];
  int       errors = 0;
  int       tx_idle = 0;   // percent of cycles the sender holds off
  int       rx_idle = 0;   // percent of cycles the receiver holds off

  // mirror of the block's registers and accumulators
  logic        mdl_mode = MODE_NORMAL;
  logic [15:0] mdl_w_red = WEIGHT_RESET;
  logic [15:0] mdl_w_green = WEIGHT_RESET;
  logic [15:0] mdl_w_blue = WEIGHT_RESET;
  logic [63:0] mdl_sum = '0;
  logic [24:0] mdl_count = '0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint normal_z(longint x, longint y);
    longint s;
    s = x * x + y * y;
    if (s > 64'sd4294967296) s = 64'sd4294967296;
    return longint'(floor_sqrt(64'd4294967296 - s));
  endfunction

  // angle between the two rebuilt normals, Q.24 radians
  function automatic logic [63:0] angle_error(pix_in_t p);
    longint x1, y1, x2, y2, z1, z2, dot, cx, cy, dx, dy, ang;
    longint unsigned d;
    x1 = 2 * longint'(p.orig_red) - 65536;
    y1 = 2 * longint'(p.orig_green) - 65536;
    x2 = 2 * longint'(p.comp_red) - 65536;
    y2 = 2 * longint'(p.comp_green) - 65536;
    z1 = normal_z(x1, y1);
    z2 = normal_z(x2, y2);
    dot = x1 * x2 + y1 * y2 + z1 * z2;
    if (dot < 0) dot = 0;
    if (dot > 64'sd4294967296) dot = 64'sd4294967296;
    d = longint'(dot) >> 2;
    cx = longint'(d);
    cy = longint'(floor_sqrt((64'd1 << 60) - d * d));
    ang = 0;
    for (int i = 0; i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += ATAN_Q24[i];
      end else begin
        cx -= dx; cy += dy; ang -= ATAN_Q24[i];
      end
    end
    if (ang < 0) ang = 0;
    return 64'(ang);
  endfunction

  function automatic logic [63:0] weighted_sq(logic [15:0] a, logic [15:0] b,
                                              logic [15:0] w);
    logic [63:0] mag;
    mag = ((a >= b) ? 64'(a - b) : 64'(b - a)) * 64'(w);
    return (mag * mag) >> 2;
  endfunction

  function automatic logic [63:0] color_error(pix_in_t p);
    logic [63:0] acc;
    acc = weighted_sq(p.orig_red, p.comp_red, mdl_w_red)
        + weighted_sq(p.orig_green, p.comp_green, mdl_w_green)
        + weighted_sq(p.orig_blue, p.comp_blue, mdl_w_blue);
    return acc >> 34;
  endfunction

  // accumulate one pair; on a final pair queue the expected mean
  task automatic accumulate_pair(pix_in_t p);
    logic [63:0] mean;
    err_out_t r;
    if (mdl_count < (25'd1 << PIX_LIMIT_LOG2)) begin
      mdl_sum += (mdl_mode == MODE_COLOR) ? color_error(p) : angle_error(p);
      mdl_count++;
    end
    if (p.final_pixel) begin
      mean = mdl_sum / 64'(mdl_count);
      r.mean_error = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
      r.pixels_seen = mdl_count;
      expected_means.push_back(r);
      mdl_sum = '0;
      mdl_count = '0;
    end
  endtask

  // sender: a new pair goes out once the previous one has transferred
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= tx_idle) begin
        pixel <= pending_pairs.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= rx_idle);
  end

  // monitor: predict on input transfers, check on result transfers
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) accumulate_pair(pixel);
      if (pop && !empty) begin
        if (expected_means.size() == 0) begin
          $error("result transfer with nothing expected: mean_error %0d pixels_seen %0d",
                 result.mean_error, result.pixels_seen);
          errors++;
        end else begin
          if (result.mean_error !== expected_means[0].mean_error) begin
            $error("mean_error: expected %0d, got %0d",
                   expected_means[0].mean_error, result.mean_error);
            errors++;
          end
          if (result.pixels_seen !== expected_means[0].pixels_seen) begin
            $error("pixels_seen: expected %0d, got %0d",
                   expected_means[0].pixels_seen, result.pixels_seen);
            errors++;
          end
          void'(expected_means.pop_front());
        end
      end
      // watchdog on lack of progress
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // config writes happen only when the block is drained
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ERROR_MODE:   mdl_mode = val[0];
      REG_WEIGHT_RED:   mdl_w_red = val;
      REG_WEIGHT_GREEN: mdl_w_green = val;
      REG_WEIGHT_BLUE:  mdl_w_blue = val;
      default: ;
    endcase
  endtask

  // hold off until every pair is in and every mean is out, then let the back end finish
  task automatic drain();
    while (pending_pairs.size() != 0 || push || expected_means.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic pix_in_t make_pair(logic [15:0] r0, logic [15:0] g0, logic [15:0] b0,
                                        logic [15:0] r1, logic [15:0] g1, logic [15:0] b1,
                                        logic last);
    pix_in_t p;
    p = '{r0, g0, b0, r1, g1, b1, last};
    return p;
  endfunction

  // channel value: mostly uniform, sometimes an extreme or the center code
  function automatic logic [15:0] rand_chan();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] near(logic [15:0] v);
    int t;
    t = int'(v) + $urandom_range(512) - 256;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return 16'(t);
  endfunction

  // a set of pairs; the compressed copy is usually close to the original
  task automatic queue_set(int len);
    pix_in_t p;
    for (int i = 0; i < len; i++) begin
      p.orig_red = rand_chan();
      p.orig_green = rand_chan();
      p.orig_blue = rand_chan();
      if ($urandom_range(3) != 0) begin
        p.comp_red = near(p.orig_red);
        p.comp_green = near(p.orig_green);
        p.comp_blue = near(p.orig_blue);
      end else begin
        p.comp_red = rand_chan();
        p.comp_green = rand_chan();
        p.comp_blue = rand_chan();
      end
      p.final_pixel = (i == len - 1);
      pending_pairs.push_back(p);
    end
  endtask

  task automatic random_config();
    logic [15:0] w [3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(4))
        0: w[i] = 16'h0000;
        1: w[i] = 16'hFFFF;
        default: w[i] = 16'($urandom);
      endcase
    end
    write_reg(REG_ERROR_MODE, 16'($urandom_range(1)));
    write_reg(REG_WEIGHT_RED, w[0]);
    write_reg(REG_WEIGHT_GREEN, w[1]);
    write_reg(REG_WEIGHT_BLUE, w[2]);
  endtask

  task automatic random_phase(int n_pairs);
    int sent, len;
    sent = 0;
    while (sent < n_pairs) begin
      random_config();
      for (int s = 0; s < 6; s++) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
        @(negedge clk);
        queue_set(len);
        sent += len;
      end
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, normal mode at reset weights
    @(negedge clk);
    pending_pairs.push_back(make_pair(16'h8000, 16'h8000, 16'h0, 16'h8000, 16'h8000, 16'h0, 1'b1));
    pending_pairs.push_back(make_pair(16'h0000, 16'h0000, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 1'b1));
    pending_pairs.push_back(make_pair(16'hFFFF, 16'h8000, 16'h0, 16'h0000, 16'h8000, 16'h0, 1'b0));
    pending_pairs.push_back(make_pair(16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 16'h0, 1'b0));
    pending_pairs.push_back(make_pair(16'h8000, 16'hFFFF, 16'h0, 16'h8000, 16'h0000, 16'h0, 1'b1));
    // mode change in the middle of a set: three angle pairs, then color pairs
    pending_pairs.push_back(make_pair(16'h4000, 16'hC000, 16'h1, 16'h5000, 16'hB000, 16'h2, 1'b0));
    pending_pairs.push_back(make_pair(16'h1234, 16'hFEDC, 16'h3, 16'h2345, 16'hEDCB, 16'h4, 1'b0));
    pending_pairs.push_back(make_pair(16'hFFFF, 16'h0000, 16'h5, 16'h0000, 16'hFFFF, 16'h6, 1'b0));
    drain();
    write_reg(REG_ERROR_MODE, 16'(MODE_COLOR));
    write_reg(REG_WEIGHT_RED, 16'hFFFF);
    write_reg(REG_WEIGHT_GREEN, 16'hFFFF);
    write_reg(REG_WEIGHT_BLUE, 16'hFFFF);
    @(negedge clk);
    pending_pairs.push_back(make_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 1'b0));
    pending_pairs.push_back(make_pair(16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    pending_pairs.push_back(make_pair(16'hAAAA, 16'h5555, 16'h1, 16'hAAAA, 16'h5555, 16'h1, 1'b1));
    drain();
    // zero weights cancel every channel
    write_reg(REG_WEIGHT_RED, 16'h0000);
    write_reg(REG_WEIGHT_GREEN, 16'h0000);
    write_reg(REG_WEIGHT_BLUE, 16'h0000);
    @(negedge clk);
    pending_pairs.push_back(make_pair(16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 1'b1));
    drain();
    // a single weight, blue, at full scale
    write_reg(REG_WEIGHT_BLUE, 16'hFFFF);
    @(negedge clk);
    pending_pairs.push_back(make_pair(16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 1'b1));
    drain();

    // random sets under three idling patterns
    tx_idle = 10; rx_idle = 78;
    random_phase(530);
    tx_idle = 78; rx_idle = 10;
    random_phase(530);
    tx_idle = 0; rx_idle = 0;
    random_phase(540);

    drain();
    if (errors == 0 && expected_means.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/icem_pkg.sv
rtl/icem_front.sv
rtl/icem_queue.sv
rtl/icem_back.sv
rtl/image_compression_error_meter.sv
bench/tb.sv
